@@ src/ribosome_exclusion_gillespie_step_top_assert.svh @@
// ----------------------------------------------------------------------------
// Ribosome exclusion step: assertion macros
// Immediate-antecedent and next-cycle property checks, clocked on aclk and
// disabled in reset. They collapse to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef RIBOSOME_EXCLUSION_GILLESPIE_STEP_TOP_ASSERT_SVH
`define RIBOSOME_EXCLUSION_GILLESPIE_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check cons in the same cycle as ante
`define RXG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rxg: same-cycle check failed");
// check cons in the cycle after ante
`define RXG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rxg: next-cycle check failed");
`else
`define RXG_ASSERT_NOW(label, ante, cons)
`define RXG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/rxg_pkg.sv @@
// ----------------------------------------------------------------------------
// Ribosome exclusion step: shared package
// Payload structs, state and command codes, fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rxg_pkg;

    localparam int DEF_MAX_RIBOSOMES = 256;
    localparam int DEF_MAX_CODONS    = 4096;
    localparam int LOG_FRAC_BITS     = 24;
    localparam int DIV_BITS          = 40;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [5:0]  DEF_EXCL_DIST = 6'd9;
    localparam logic [11:0] DEF_GENE_LEN  = 12'd1;
    localparam logic        OPC_LOAD = 1'b0;

    typedef enum logic [2:0] {
        CFG_INIT_RATE  = 3'd0,
        CFG_COMP_RATE  = 3'd1,
        CFG_GENE_LEN   = 3'd2,
        CFG_EXCL_DIST  = 3'd3,
        CFG_INH_START  = 3'd4,
        CFG_INH_EN     = 3'd5,
        CFG_START_TIME = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_LOAD  = 3'd0,
        EV_INIT  = 3'd1,
        EV_ELONG = 3'd2,
        EV_COMP  = 3'd3,
        EV_STALL = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic        operation;
        logic [11:0] codon_index;
        logic [31:0] codon_rate;
        logic [31:0] uniform_time;
        logic [31:0] uniform_choice;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [47:0] sim_time;
        logic [7:0]  ribosome_slot;
        logic [11:0] new_position;
        logic [47:0] transit_time;
        logic [15:0] finished_collisions;
        logic        collided;
        logic [31:0] ribosomes_started;
        logic [8:0]  active_ribosomes;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD,
        ST_P1_ADDR, ST_P1_RATE, ST_P1_ACC, ST_P1_END, ST_A0_CHK, ST_STALL,
        ST_NORM, ST_SQ_MUL, ST_SQ_UPD, ST_LN_MUL, ST_LN_GET, ST_DIV,
        ST_TGT_LO, ST_TGT_HI, ST_TGT_SUM,
        ST_P2_ADDR, ST_P2_RATE, ST_P2_ACC,
        ST_INIT, ST_ELG_RD, ST_ELG, ST_COMP_RD, ST_COMP, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_LOAD, OP_WALK_RATE, OP_P1_ACC, OP_P1_END,
        OP_STALL, OP_NORM, OP_SQ_MUL, OP_SQ_UPD, OP_LN_MUL, OP_LN_GET,
        OP_DIV, OP_TGT_LO, OP_TGT_HI, OP_TGT_SUM, OP_P2_ACC,
        OP_INIT, OP_ELG, OP_COMP, OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic cnt_zero;
        logic last_entry;
        logic match;
        logic is_comp;
        logic a0_zero;
        logic u_norm;
        logic k_last;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

@@ src/rxg_dpath.sv @@
// ----------------------------------------------------------------------------
// Ribosome exclusion step: datapath
// Ribosome ring memories, codon rate memory, shared multiplier, restoring
// divider, log iteration, config registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rxg_dpath #(
    parameter int MAX_RIBOSOMES = rxg_pkg::DEF_MAX_RIBOSOMES,
    parameter int MAX_CODONS    = rxg_pkg::DEF_MAX_CODONS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rxg_pkg::cmd_t    cmd,
    output rxg_pkg::status_t      status,
    input  wire rxg_pkg::in_t     s_data,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [47:0]      cfg_data,
    output rxg_pkg::out_t         m_data
);
    import rxg_pkg::*;

    localparam int PW  = $clog2(MAX_RIBOSOMES);
    localparam int CW  = $clog2(MAX_RIBOSOMES + 1);
    localparam int A0W = 32 + CW;
    localparam int AW  = $clog2(MAX_CODONS);

    // configuration
    logic [31:0] init_rate_reg, comp_rate_reg;
    logic [11:0] gene_len_reg;
    logic [5:0]  excl_reg;
    logic [47:0] inh_start_reg, start_time_reg;
    logic        inh_en_reg;

    // traffic state
    logic [47:0]   cur_time_reg;
    logic [31:0]   started_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] head_reg;

    // working registers
    logic [11:0]    codon_idx_reg;
    logic [31:0]    codon_rate_reg, u_reg, u2_reg;
    logic [4:0]     n_reg, k_reg;
    logic [23:0]    frac_reg;
    logic [63:0]    prod_reg;
    logic [DIV_BITS-1:0] dq_reg;
    logic [A0W:0]   rem_reg;
    logic [5:0]     dcnt_reg;
    logic [A0W-1:0] a0_reg, run_reg, target_reg;
    logic [31:0]    lo_hi_reg;
    logic [CW-1:0]  i_reg;
    logic [11:0]    cur_pos_reg, prev_pos_reg;
    out_t           res_reg, m_data_reg;

    // memories
    logic [11:0] pos_mem  [MAX_RIBOSOMES];
    logic [47:0] ent_mem  [MAX_RIBOSOMES];
    logic [15:0] coll_mem [MAX_CODONS > 0 ? MAX_RIBOSOMES : 1];
    logic [31:0] rate_mem [MAX_CODONS];
    logic [11:0] pos_q;
    logic [47:0] ent_q;
    logic [15:0] coll_q;
    logic [31:0] rate_q;

    // combinational
    logic [5:0]     dist_eff;
    logic [CW-1:0]  idx;
    logic [31:0]    phys_sum, phys_wrap;
    logic [PW-1:0]  slot_addr;
    logic [31:0]    rate_rd_idx, rate_wr_idx, cur_idx;
    logic [AW-1:0]  rate_raddr;
    logic           rate_ok, blocked, comp_here, inh_active, init_ok;
    logic [31:0]    w, init_w;
    logic [A0W-1:0] run_sum;
    logic [31:0]    mul_a, mul_b;
    logic [32:0]    m_new;
    logic [29:0]    e_val;
    logic [A0W:0]   rem_sh;
    logic           div_ge;
    logic [48:0]    t_sum;
    logic [47:0]    t_sat;
    logic [64:0]    tgt_sum;
    logic [11:0]    np;
    logic [12:0]    np_plus;
    logic           elg_col, init_col;
    logic [31:0]    slot_ext, cnt_ext;

    // build one result word; fields that mean nothing stay zero
    function automatic out_t make_res(event_kind_t kind, logic [7:0] slot,
                                      logic [11:0] pos, logic [47:0] transit,
                                      logic [15:0] fin, logic col);
        out_t r;
        r = '0;
        r.event_kind          = kind;
        r.ribosome_slot       = slot;
        r.new_position        = pos;
        r.transit_time        = transit;
        r.finished_collisions = fin;
        r.collided            = col;
        return r;
    endfunction

    assign dist_eff = (excl_reg == '0) ? 6'd1 : excl_reg;

    // ring slot address of the logical entry in use
    assign idx       = (cmd.op == OP_INIT) ? cnt_reg : i_reg;
    assign phys_sum  = 32'(head_reg) + 32'(idx);
    assign phys_wrap = (phys_sum >= 32'(MAX_RIBOSOMES)) ?
                       phys_sum - 32'(MAX_RIBOSOMES) : phys_sum;
    assign slot_addr = phys_wrap[PW-1:0];

    // codon rate lookup for the position just read
    assign rate_rd_idx = 32'(pos_q) - 32'd1;
    assign rate_raddr  = rate_rd_idx[AW-1:0];
    assign rate_wr_idx = 32'(codon_idx_reg);
    assign cur_idx     = 32'(cur_pos_reg) - 32'd1;
    assign rate_ok     = (cur_pos_reg != '0) && (cur_idx < 32'(MAX_CODONS));

    // per-ribosome propensity
    assign blocked   = (i_reg != '0) &&
                       ({1'b0, prev_pos_reg} <= ({1'b0, cur_pos_reg} + 13'(dist_eff)));
    assign comp_here = (i_reg == '0) && (cur_pos_reg >= gene_len_reg);
    always_comb begin
        if (comp_here) begin
            w = comp_rate_reg;
        end else if (blocked || !rate_ok) begin
            w = '0;
        end else begin
            w = rate_q;
        end
    end
    assign run_sum = run_reg + A0W'(w);

    // initiation propensity
    assign inh_active = inh_en_reg && (cur_time_reg >= inh_start_reg);
    assign init_ok    = (32'(cnt_reg) < 32'(MAX_RIBOSOMES)) &&
                        ((cnt_reg == '0) || (prev_pos_reg > 12'(dist_eff))) && !inh_active;
    assign init_w     = init_ok ? init_rate_reg : '0;
    assign init_col   = (cnt_reg != '0) && (prev_pos_reg == 12'(dist_eff) + 12'd1);

    // shared multiplier operands
    assign e_val = 30'(32'd32 << LOG_FRAC_BITS) - 30'({n_reg, frac_reg});
    always_comb begin
        case (cmd.op)
            OP_SQ_MUL: begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
            OP_LN_MUL: begin
                mul_a = 32'(e_val);
                mul_b = LN2_Q32;
            end
            OP_TGT_LO: begin
                mul_a = a0_reg[31:0];
                mul_b = u2_reg;
            end
            OP_TGT_HI: begin
                mul_a = 32'(a0_reg[A0W-1:32]);
                mul_b = u2_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign m_new   = prod_reg[63:31];
    assign rem_sh  = {rem_reg[A0W-1:0], dq_reg[DIV_BITS-1]};
    assign div_ge  = rem_sh >= {1'b0, a0_reg};
    assign t_sum   = {1'b0, cur_time_reg} + 49'(dq_reg);
    assign t_sat   = t_sum[48] ? TIME_MAX : t_sum[47:0];
    assign tgt_sum = {1'b0, prod_reg} + 65'(lo_hi_reg);
    assign np      = cur_pos_reg + 12'd1;
    assign np_plus = {1'b0, np} + 13'(dist_eff);
    assign elg_col = (i_reg != '0) && ({1'b0, prev_pos_reg} == np_plus);
    assign slot_ext = 32'(i_reg);
    assign cnt_ext  = 32'(cnt_reg);

    // status to the controller
    always_comb begin
        status.is_load    = (s_data.operation == OPC_LOAD);
        status.cnt_zero   = (cnt_reg == '0);
        status.last_entry = ((32'(i_reg) + 32'd1) == 32'(cnt_reg));
        status.match      = (run_sum > target_reg);
        status.is_comp    = comp_here;
        status.a0_zero    = (a0_reg == '0);
        status.u_norm     = u_reg[31];
        status.k_last     = (k_reg == 5'(LOG_FRAC_BITS - 1));
        status.div_last   = (dcnt_reg == 6'(DIV_BITS - 1));
    end

    // memory ports: registered reads every cycle
    always_ff @(posedge aclk) begin
        pos_q  <= pos_mem[slot_addr];
        ent_q  <= ent_mem[slot_addr];
        coll_q <= coll_mem[slot_addr];
        rate_q <= rate_mem[rate_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INIT) begin
            pos_mem[slot_addr] <= 12'd1;
        end else if (cmd.op == OP_ELG) begin
            pos_mem[slot_addr] <= np;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INIT) begin
            ent_mem[slot_addr] <= cur_time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INIT) begin
            coll_mem[slot_addr] <= 16'(init_col);
        end else if (cmd.op == OP_ELG && elg_col && coll_q != 16'hFFFF) begin
            coll_mem[slot_addr] <= coll_q + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD && rate_wr_idx < 32'(MAX_CODONS)) begin
            rate_mem[rate_wr_idx[AW-1:0]] <= codon_rate_reg;
        end
    end

    // configuration and traffic state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_rate_reg  <= '0;
            comp_rate_reg  <= '0;
            gene_len_reg   <= DEF_GENE_LEN;
            excl_reg       <= DEF_EXCL_DIST;
            inh_start_reg  <= '0;
            inh_en_reg     <= 1'b0;
            start_time_reg <= '0;
            cur_time_reg   <= '0;
            started_reg    <= '0;
            cnt_reg        <= '0;
            head_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_INIT_RATE:  init_rate_reg <= cfg_data[31:0];
                    CFG_COMP_RATE:  comp_rate_reg <= cfg_data[31:0];
                    CFG_GENE_LEN:   gene_len_reg  <= cfg_data[11:0];
                    CFG_EXCL_DIST:  excl_reg      <= cfg_data[5:0];
                    CFG_INH_START:  inh_start_reg <= cfg_data;
                    CFG_INH_EN:     inh_en_reg    <= cfg_data[0];
                    CFG_START_TIME: begin
                        start_time_reg <= cfg_data;
                        cur_time_reg   <= cfg_data;
                    end
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_TGT_SUM: cur_time_reg <= t_sat;
                OP_INIT: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (started_reg != 32'hFFFF_FFFF) begin
                        started_reg <= started_reg + 32'd1;
                    end
                end
                OP_COMP: begin
                    cnt_reg  <= cnt_reg - CW'(1);
                    head_reg <= (32'(head_reg) == 32'(MAX_RIBOSOMES - 1)) ?
                                '0 : head_reg + PW'(1);
                end
                default: ;
            endcase
        end
    end

    // event working registers
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.op)
            OP_LATCH: begin
                codon_idx_reg  <= s_data.codon_index;
                codon_rate_reg <= s_data.codon_rate;
                u_reg    <= (s_data.uniform_time == '0) ? 32'd1 : s_data.uniform_time;
                u2_reg   <= s_data.uniform_choice;
                n_reg    <= 5'd31;
                k_reg    <= '0;
                frac_reg <= '0;
                a0_reg   <= '0;
                i_reg    <= '0;
            end
            OP_LOAD: res_reg <= make_res(EV_LOAD, '0, '0, '0, '0, 1'b0);
            OP_WALK_RATE: cur_pos_reg <= pos_q;
            OP_P1_ACC: begin
                a0_reg       <= a0_reg + A0W'(w);
                prev_pos_reg <= cur_pos_reg;
                if (!status.last_entry) begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            OP_P1_END: a0_reg <= a0_reg + A0W'(init_w);
            OP_STALL: res_reg <= make_res(EV_STALL, '0, '0, '0, '0, 1'b0);
            OP_NORM: begin
                if (!u_reg[31]) begin
                    u_reg <= {u_reg[30:0], 1'b0};
                    n_reg <= n_reg - 5'd1;
                end
            end
            OP_SQ_UPD: begin
                frac_reg <= {frac_reg[22:0], m_new[32]};
                u_reg    <= m_new[32] ? m_new[32:1] : m_new[31:0];
                k_reg    <= k_reg + 5'd1;
            end
            OP_LN_GET: begin
                dq_reg   <= {prod_reg[63:32], 8'd0};
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV: begin
                rem_reg  <= div_ge ? rem_sh - {1'b0, a0_reg} : rem_sh;
                dq_reg   <= {dq_reg[DIV_BITS-2:0], div_ge};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            OP_TGT_HI: lo_hi_reg <= prod_reg[63:32];
            OP_TGT_SUM: begin
                target_reg <= tgt_sum[A0W-1:0];
                run_reg    <= '0;
                i_reg      <= '0;
            end
            OP_P2_ACC: begin
                run_reg <= run_sum;
                if (!status.match) begin
                    prev_pos_reg <= cur_pos_reg;
                    if (!status.last_entry) begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
            end
            OP_INIT: res_reg <= make_res(EV_INIT, cnt_ext[7:0], 12'd1, '0, '0, init_col);
            OP_ELG: res_reg <= make_res(EV_ELONG, slot_ext[7:0], np, '0, '0, elg_col);
            OP_COMP: begin
                res_reg <= make_res(EV_COMP, '0, '0,
                                    (cur_time_reg >= ent_q) ? cur_time_reg - ent_q : '0,
                                    coll_q, 1'b0);
            end
            OP_OUT_LOAD: begin
                m_data_reg <= {res_reg.event_kind, cur_time_reg, res_reg.ribosome_slot,
                               res_reg.new_position, res_reg.transit_time,
                               res_reg.finished_collisions, res_reg.collided,
                               started_reg, cnt_ext[8:0]};
            end
            default: ;
        endcase
    end

    assign m_data = m_data_reg;

endmodule

`default_nettype wire

@@ src/rxg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ribosome exclusion step: controller
// Sequences rate loads, the propensity pass, log, division, selection pass
// and the event update, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rxg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire rxg_pkg::status_t  status,
    output rxg_pkg::cmd_t          cmd
);
    import rxg_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg;

    // state register and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.op == OP_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                    if (status.is_load) begin
                        state_next = ST_LOAD;
                    end else if (status.cnt_zero) begin
                        state_next = ST_P1_END;
                    end else begin
                        state_next = ST_P1_ADDR;
                    end
                end
            end
            ST_LOAD: begin
                cmd.op     = OP_LOAD;
                state_next = ST_FINISH;
            end
            ST_P1_ADDR: state_next = ST_P1_RATE;
            ST_P1_RATE: begin
                cmd.op     = OP_WALK_RATE;
                state_next = ST_P1_ACC;
            end
            ST_P1_ACC: begin
                cmd.op     = OP_P1_ACC;
                state_next = status.last_entry ? ST_P1_END : ST_P1_ADDR;
            end
            ST_P1_END: begin
                cmd.op     = OP_P1_END;
                state_next = ST_A0_CHK;
            end
            ST_A0_CHK: state_next = status.a0_zero ? ST_STALL : ST_NORM;
            ST_STALL: begin
                cmd.op     = OP_STALL;
                state_next = ST_FINISH;
            end
            ST_NORM: begin
                cmd.op = OP_NORM;
                if (status.u_norm) begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                cmd.op     = OP_SQ_MUL;
                state_next = ST_SQ_UPD;
            end
            ST_SQ_UPD: begin
                cmd.op     = OP_SQ_UPD;
                state_next = status.k_last ? ST_LN_MUL : ST_SQ_MUL;
            end
            ST_LN_MUL: begin
                cmd.op     = OP_LN_MUL;
                state_next = ST_LN_GET;
            end
            ST_LN_GET: begin
                cmd.op     = OP_LN_GET;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (status.div_last) begin
                    state_next = ST_TGT_LO;
                end
            end
            ST_TGT_LO: begin
                cmd.op     = OP_TGT_LO;
                state_next = ST_TGT_HI;
            end
            ST_TGT_HI: begin
                cmd.op     = OP_TGT_HI;
                state_next = ST_TGT_SUM;
            end
            ST_TGT_SUM: begin
                cmd.op     = OP_TGT_SUM;
                state_next = status.cnt_zero ? ST_INIT : ST_P2_ADDR;
            end
            ST_P2_ADDR: state_next = ST_P2_RATE;
            ST_P2_RATE: begin
                cmd.op     = OP_WALK_RATE;
                state_next = ST_P2_ACC;
            end
            ST_P2_ACC: begin
                cmd.op = OP_P2_ACC;
                if (status.match) begin
                    state_next = status.is_comp ? ST_COMP_RD : ST_ELG_RD;
                end else if (status.last_entry) begin
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_P2_ADDR;
                end
            end
            ST_INIT: begin
                cmd.op     = OP_INIT;
                state_next = ST_FINISH;
            end
            ST_ELG_RD: state_next = ST_ELG;
            ST_ELG: begin
                cmd.op     = OP_ELG;
                state_next = ST_FINISH;
            end
            ST_COMP_RD: state_next = ST_COMP;
            ST_COMP: begin
                cmd.op     = OP_COMP;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ src/ribosome_exclusion_gillespie_step_top.sv @@
// ----------------------------------------------------------------------------
// Ribosome exclusion Gillespie step: top level
// One stochastic event (or one codon rate load) per input beat on a transcript
// with an exclusion distance; ribosomes kept in a ring, lead first.
//
//   channel  | ports                          | beat carries
//   ---------+--------------------------------+------------------------------
//   input    | s_valid  s_ready  s_data       | load or step item
//   result   | m_valid  m_ready  m_data       | one result per input beat
//   config   | cfg_valid cfg_ready cfg_index  | register index and cfg_data
//
// A step makes at most two walks over the ribosome ring through the
// registered memory ports, 24 squarings on the shared multiplier and a
// 40-step restoring divider. A step whose total propensity is zero ends
// as a stall after the first walk.
// Reset is synchronous; there is no memory clearing pass.
// A result held by m_ready low stalls only the end of the next item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ribosome_exclusion_gillespie_step_top_assert.svh"

module ribosome_exclusion_gillespie_step_top #(
    parameter int MAX_RIBOSOMES = rxg_pkg::DEF_MAX_RIBOSOMES,
    parameter int MAX_CODONS    = rxg_pkg::DEF_MAX_CODONS
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rxg_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rxg_pkg::out_t       m_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [47:0]    cfg_data
);
    import rxg_pkg::*;

    cmd_t    cmd;
    status_t status;

    // config writes are always accepted and registered
    assign cfg_ready = 1'b1;

    rxg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rxg_dpath #(
        .MAX_RIBOSOMES (MAX_RIBOSOMES),
        .MAX_CODONS    (MAX_CODONS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

    // an accepted item keeps the input closed until its result is formed
    `RXG_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // a completed ribosome has left the transcript
    `RXG_ASSERT_NOW(a_comp_left, m_valid && m_data.event_kind == EV_COMP, m_data.new_position == 12'd0 && m_data.collided == 1'b0)
    // a load result reports no ribosome movement
    `RXG_ASSERT_NOW(a_load_quiet, m_valid && m_data.event_kind == EV_LOAD, m_data.transit_time == 48'd0 && m_data.new_position == 12'd0)

endmodule

`default_nettype wire
